/* src/sca_pkg.sv */
package sca_pkg;

  // Default character buffer depth
  localparam int FIFO_DEPTH_DEF = 128;

  // Input item kinds (carried in tuser)
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Set-1 scan codes with special handling
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] SC_NUM_MAKE     = 8'h45;
  localparam logic [7:0] SC_SCROLL_MAKE  = 8'h46;
  localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
  localparam logic [7:0] SC_F1_MAKE      = 8'h3B;
  localparam logic [7:0] SC_F10_MAKE     = 8'h44;

  // Number of entries in each character table
  localparam int TABLE_LEN = 84;

  // LED byte bits
  localparam logic [2:0] LED_SCROLL = 3'b001;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_CAPS   = 3'b100;

  // Control from the decoder to the buffer
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  // Control from the buffer to each storage cell
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Result item as packed on the output tdata, lowest field last
  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] fifo_count;
    logic [2:0] led_bits;
    logic       led_write;
    logic       char_valid;
    logic [7:0] char_out;
  } result_t;

  localparam logic [7:0] TAB_PLAIN [0:TABLE_LEN-1] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h80,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3B, 8'h27, 8'h60, 8'h80,
    8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
    8'h2C, 8'h2E, 8'h2F, 8'h80,
    8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h30, 8'h7F
  };

  localparam logic [7:0] TAB_SHIFT [0:TABLE_LEN-1] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h80,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h80,
    8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
    8'h3C, 8'h3E, 8'h3F, 8'h80,
    8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h37, 8'h38, 8'h39, 8'h80,
    8'h34, 8'h35, 8'h36, 8'h80,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
  };

  localparam logic [7:0] TAB_CAPS [0:TABLE_LEN-1] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h0D, 8'h80,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3B, 8'h27, 8'h60, 8'h80,
    8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
    8'h2C, 8'h2E, 8'h2F, 8'h80,
    8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h30, 8'h7F
  };

  localparam logic [7:0] TAB_CAPS_SHIFT [0:TABLE_LEN-1] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h7B, 8'h7D, 8'h0D, 8'h80,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3A, 8'h22, 8'h7E, 8'h80,
    8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
    8'h3C, 8'h3E, 8'h3F, 8'h80,
    8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h37, 8'h38, 8'h39, 8'h80,
    8'h34, 8'h35, 8'h36, 8'h80,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
  };

  // Character for a make code; codes past the tables give 0
  function automatic logic [7:0] lookup(input logic [7:0] code, input logic shift,
                                        input logic caps);
    logic [6:0] idx;
    logic [7:0] ch;
    idx = code[6:0];
    ch  = 8'h00;
    if (code < 8'(TABLE_LEN)) begin
      unique case ({shift, caps})
        2'b00:   ch = TAB_PLAIN[idx];
        2'b01:   ch = TAB_CAPS[idx];
        2'b10:   ch = TAB_SHIFT[idx];
        default: ch = TAB_CAPS_SHIFT[idx];
      endcase
    end
    return ch;
  endfunction

endpackage

/* src/sca_cell.sv */
module sca_cell (
  input  logic                clk,
  input  sca_pkg::cell_ctrl_t ctl,
  input  logic [7:0]          load_data,
  input  logic [7:0]          next_data,
  output logic [7:0]          data
);

  // Load a new character, or take the neighbor's one on a pop
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= load_data;
    end else if (ctl.shift) begin
      data <= next_data;
    end
  end

endmodule

/* src/sca_chain.sv */
module sca_chain #(
  parameter  int DEPTH = sca_pkg::FIFO_DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  sca_pkg::fifo_ctrl_t ctrl,
  input  logic [7:0]          push_data,
  output logic [CNT_W-1:0]    count,
  output logic [CNT_W-1:0]    count_next,
  output logic [7:0]          head
);

  localparam int IDX_W = $clog2(DEPTH);

  logic             full;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       cell_data [DEPTH];

  // Write slot: first free cell, or the newest one when full
  assign full   = (count == CNT_W'(DEPTH));
  assign wr_idx = full ? IDX_W'(DEPTH - 1) : count[IDX_W-1:0];

  // Fill count
  always_comb begin
    count_next = count;
    if (ctrl.push && !full) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Row of cells, oldest character in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sca_pkg::cell_ctrl_t ctl;
    logic [7:0]          nbr;

    assign ctl.load  = ctrl.push && (wr_idx == IDX_W'(i));
    assign ctl.shift = ctrl.pop;

    if (i == DEPTH - 1) begin : g_last
      assign nbr = 8'h00;
    end else begin : g_mid
      assign nbr = cell_data[i + 1];
    end

    sca_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_data (push_data),
      .next_data (nbr),
      .data      (cell_data[i])
    );
  end

  assign head = cell_data[0];

endmodule

/* src/scan_code_to_ascii_fifo.sv */
// Set-1 keyboard scan code to character converter with a character buffer.
// Input channel (s_*): each item is either a scan code byte (tuser = 0) or a
// request to read one buffered character (tuser = 1). Output channel (m_*):
// exactly one result item per input item, in order, carrying the popped
// character, its valid flag, an LED-update flag, the LED byte and the number
// of buffered characters after the item.
// Results are registered in the output register. Throughput is one item per
// cycle while the receiver does not stall; decode, table lookup and the
// buffer update all finish in the cycle the item is taken, and the buffer is
// a row of shift cells read at cell 0 and written at the fill count.
// When the receiver stalls, one further item is held in a skid register
// behind the output register; s_tready then drops until m_tready returns.
// Reset clears the shift and caps flags, the LED byte, the fill count and
// the output and skid valid flags; buffered characters are dropped and no
// clearing pass runs, so items are taken from the first cycle after reset.
module scan_code_to_ascii_fifo #(
  parameter int FIFO_DEPTH = sca_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] scan_code
  input  logic [0:0]  s_tuser,  // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // [7:0] char_out, [8] char_valid, [9] led_write,
                                // [12:10] led_bits, [20:13] fifo_count, [23:21] zero
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic                accept;
  logic                cmd;
  logic [7:0]          scan_code;
  logic                shift_held, shift_held_next;
  logic                caps_on, caps_on_next;
  logic [2:0]          led_state, led_state_next;
  logic                do_push, do_pop, led_write;
  logic [7:0]          push_char;
  logic [CNT_W-1:0]    count, count_next;
  logic [7:0]          head;
  sca_pkg::fifo_ctrl_t fctrl;
  sca_pkg::result_t    result, out_reg, skid_reg;
  logic                skid_full;

  assign cmd       = s_tuser[0];
  assign scan_code = s_tdata;
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !skid_full;

  // Item decode
  always_comb begin
    shift_held_next = shift_held;
    caps_on_next    = caps_on;
    led_state_next  = led_state;
    do_push         = 1'b0;
    do_pop          = 1'b0;
    led_write       = 1'b0;
    if (cmd == sca_pkg::CMD_READ) begin
      do_pop = (count != '0);
    end else begin
      unique case (scan_code)
        sca_pkg::SC_LSHIFT_MAKE, sca_pkg::SC_RSHIFT_MAKE: shift_held_next = 1'b1;
        sca_pkg::SC_LSHIFT_BREAK, sca_pkg::SC_RSHIFT_BREAK: shift_held_next = 1'b0;
        sca_pkg::SC_CAPS_MAKE: begin
          caps_on_next   = !caps_on;
          led_state_next = led_state ^ sca_pkg::LED_CAPS;
          led_write      = 1'b1;
        end
        sca_pkg::SC_NUM_MAKE: begin
          led_state_next = led_state ^ sca_pkg::LED_NUM;
          led_write      = 1'b1;
        end
        sca_pkg::SC_SCROLL_MAKE: begin
          led_state_next = led_state ^ sca_pkg::LED_SCROLL;
          led_write      = 1'b1;
        end
        sca_pkg::SC_CTRL_MAKE, sca_pkg::SC_ALT_MAKE: ;
        default: begin
          // breaks, prefix and codes past the tables all fail the range check
          do_push = (scan_code < 8'(sca_pkg::TABLE_LEN)) &&
                    !((scan_code >= sca_pkg::SC_F1_MAKE) &&
                      (scan_code <= sca_pkg::SC_F10_MAKE));
        end
      endcase
    end
  end

  assign push_char  = sca_pkg::lookup(scan_code, shift_held, caps_on);
  assign fctrl.push = accept && do_push;
  assign fctrl.pop  = accept && do_pop;

  // Keyboard state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
      led_state  <= '0;
    end else if (accept) begin
      shift_held <= shift_held_next;
      caps_on    <= caps_on_next;
      led_state  <= led_state_next;
    end
  end

  // Character buffer
  sca_chain #(
    .DEPTH (FIFO_DEPTH)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (fctrl),
    .push_data  (push_char),
    .count      (count),
    .count_next (count_next),
    .head       (head)
  );

  // Result of the current item
  always_comb begin
    result            = '0;
    result.char_out   = do_pop ? head : 8'h00;
    result.char_valid = do_pop;
    result.led_write  = led_write;
    result.led_bits   = led_state_next;
    result.fifo_count = 8'(count_next);
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (!m_tvalid || m_tready) begin
        if (skid_full) begin
          m_tvalid  <= 1'b1;
          skid_full <= 1'b0;
        end else begin
          m_tvalid <= accept;
        end
      end else if (accept) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_reg <= skid_full ? skid_reg : result;
    end
    if (accept && m_tvalid && !m_tready) begin
      skid_reg <= result;
    end
  end

  assign m_tdata = out_reg;

  // A held skid item always sits behind a valid output item
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> m_tvalid)
    else $error("skid register full while output is empty");

  // Fill count never passes the buffer depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("fill count beyond buffer depth");

  // A successful read removes exactly one character
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    fctrl.pop |=> count == $past(count) - CNT_W'(1))
    else $error("read did not lower the fill count by one");

  // The LED byte changes only on an item that flags an LED write
  a_led_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && !led_write) |=> led_state == $past(led_state))
    else $error("LED byte changed without an LED write");

endmodule
